// ===== hw/rtl/greedy_word_wrap_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Greedy word wrap unit assertion macros
// Implication checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_UNIT_MACROS_SVH
`define GREEDY_WORD_WRAP_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GWW_ASSERT_IMPL(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("gww: same-cycle check failed");
// next-cycle implication
`define GWW_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("gww: next-cycle check failed");
`else
`define GWW_ASSERT_IMPL(label, cond, prop)
`define GWW_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ===== hw/rtl/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Word types, controller states, and the command/status bundles.
// ----------------------------------------------------------------------------
package gww_pkg;

	localparam logic [7:0] SPACE_CHAR   = 8'd32;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;

	typedef struct packed {
		logic [7:0] char_in;
		logic       msg_end;
	} text_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       final_out;
	} line_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_LOAD,
		ST_NEWLINE
	} state_t;

	typedef enum logic [1:0] {
		PLAN_NONE,
		PLAN_SPACE,
		PLAN_HARD,
		PLAN_REST
	} plan_t;

	typedef struct packed {
		logic  accept;
		plan_t plan;
		logic  rd_en;
		logic  load_byte;
		logic  load_nl;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic at_width;
		logic empty;
		logic sp_valid;
		logic last;
		logic byte_last;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/greedy_word_wrap_unit.sv =====
// ----------------------------------------------------------------------------
// Greedy word wrap unit
// Rewraps a byte stream into lines of at most WIDTH characters.
// ----------------------------------------------------------------------------
// A byte that causes no line break goes through accept, then a break
// decision. When the store reaches WIDTH+1 bytes, or at message end, the
// unit emits a line of L bytes plus a newline, each byte read from the
// store and then loaded for output (waiting while the output stalls),
// then decides again; input is held off meanwhile. The byte rate during
// a line is set by the single registered read port of the circular line
// store. The break position is tracked as bytes arrive, so no search
// pass is needed. The store needs no clearing after reset.
`include "greedy_word_wrap_unit_macros.svh"

module greedy_word_wrap_unit
	import gww_pkg::*;
#(
	parameter int WIDTH = 32
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  text_valid,
	output logic  text_ready,
	input  text_t text_word,
	output logic  line_valid,
	input  logic  line_ready,
	output line_t line_word
);

	cmd_t    cmd;
	status_t status;

	gww_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.status     (status),
		.cmd        (cmd)
	);

	gww_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_word  (text_word),
		.cmd        (cmd),
		.status     (status),
		.line_valid (line_valid),
		.line_ready (line_ready),
		.line_word  (line_word)
	);

	// a full store must be drained before another word comes in
	`GWW_ASSERT_IMPL(a_no_accept_when_full, status.full, !text_ready)
	// the output register is only loaded into a free slot
	`GWW_ASSERT_IMPL(a_load_into_free, cmd.load_byte || cmd.load_nl, status.out_free)
	// each accepted word is followed by a decision cycle
	`GWW_ASSERT_NEXT(a_decide_after_accept, text_valid && text_ready, !text_ready)

endmodule

// ===== hw/rtl/gww_ctrl.sv =====
// ----------------------------------------------------------------------------
// Greedy word wrap controller
// Sequences accept, break decision, line readout and newline insertion.
// ----------------------------------------------------------------------------
module gww_ctrl
	import gww_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    text_valid,
	output logic    text_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		text_ready = 1'b0;
		cmd        = '{accept: 1'b0, plan: PLAN_NONE, rd_en: 1'b0,
			load_byte: 1'b0, load_nl: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				text_ready = 1'b1;
				if (text_valid) begin
					cmd.accept = 1'b1;
					state_n    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.full) begin
					cmd.plan = status.sp_valid ? PLAN_SPACE : PLAN_HARD;
					state_n  = ST_READ;
				end else if (status.last && !status.empty) begin
					// exactly-WIDTH remainder still gets a space search
					if (status.at_width) begin
						cmd.plan = status.sp_valid ? PLAN_SPACE : PLAN_HARD;
					end else begin
						cmd.plan = PLAN_REST;
					end
					state_n = ST_READ;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_n   = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.load_byte = 1'b1;
					state_n       = status.byte_last ? ST_NEWLINE : ST_READ;
				end
			end
			ST_NEWLINE: begin
				if (status.out_free) begin
					cmd.load_nl = 1'b1;
					state_n     = ST_DECIDE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/gww_datapath.sv =====
// ----------------------------------------------------------------------------
// Greedy word wrap datapath
// Circular line store, fill/space tracking, line plan and output register.
// ----------------------------------------------------------------------------
module gww_datapath
	import gww_pkg::*;
#(
	parameter int WIDTH = 32
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  text_t   text_word,
	input  cmd_t    cmd,
	output status_t status,
	output logic    line_valid,
	input  logic    line_ready,
	output line_t   line_word
);

	localparam int DEPTH = WIDTH + 1;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(WIDTH + 2);
	localparam logic [CNT_W-1:0] WIDTH_C  = CNT_W'(WIDTH);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
		return (ptr == LAST_PTR) ? '0 : ptr + PTR_W'(1);
	endfunction

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rdata_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] sp_q;
	logic             sp_valid_q;
	logic             last_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] drop_q;
	logic [CNT_W-1:0] cnt_q;
	logic             final_q;
	logic             line_valid_q;
	line_t            line_q;

	logic [CNT_W-1:0] len_n;
	logic [CNT_W-1:0] drop_n;
	logic [CNT_W:0]   head_sum;
	logic [PTR_W-1:0] head_n;
	logic             out_free;

	assign out_free = !line_valid_q || line_ready;

	always_comb begin
		len_n  = fill_q;
		drop_n = fill_q;
		case (cmd.plan)
			PLAN_SPACE: begin
				// the break space itself is dropped
				len_n  = sp_q;
				drop_n = sp_q + CNT_W'(1);
			end
			PLAN_HARD: begin
				len_n  = WIDTH_C;
				drop_n = WIDTH_C;
			end
			default: begin
				len_n  = fill_q;
				drop_n = fill_q;
			end
		endcase
	end

	always_comb begin
		head_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(drop_q);
		if (head_sum >= (CNT_W + 1)'(DEPTH)) begin
			head_sum = head_sum - (CNT_W + 1)'(DEPTH);
		end
		head_n = head_sum[PTR_W-1:0];
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mem[tail_q] <= text_word.char_in;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			sp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				tail_q <= wrap_inc(tail_q);
				fill_q <= fill_q + CNT_W'(1);
				// a space at the line head is text, never a break point
				if (text_word.char_in == SPACE_CHAR && fill_q != '0) begin
					sp_valid_q <= 1'b1;
				end
			end else if (cmd.load_nl) begin
				// nothing kept after a drop can be a space
				head_q     <= head_n;
				fill_q     <= fill_q - drop_q;
				sp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			last_q <= text_word.msg_end;
			if (text_word.char_in == SPACE_CHAR && fill_q != '0) begin
				sp_q <= fill_q;
			end
		end
		if (cmd.plan != PLAN_NONE) begin
			len_q    <= len_n;
			drop_q   <= drop_n;
			final_q  <= last_q && (fill_q == drop_n);
			cnt_q    <= '0;
			rd_ptr_q <= head_q;
		end else begin
			if (cmd.rd_en) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (cmd.load_byte) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= 1'b0;
		end else if (cmd.load_byte || cmd.load_nl) begin
			line_valid_q <= 1'b1;
		end else if (line_ready) begin
			line_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			line_q <= '{char_out: rdata_q, final_out: 1'b0};
		end else if (cmd.load_nl) begin
			line_q <= '{char_out: NEWLINE_CHAR, final_out: final_q};
		end
	end

	assign line_valid = line_valid_q;
	assign line_word  = line_q;

	assign status = '{
		full:      (fill_q == DEPTH_C),
		at_width:  (fill_q == WIDTH_C),
		empty:     (fill_q == '0),
		sp_valid:  sp_valid_q,
		last:      last_q,
		byte_last: (cnt_q == len_q - CNT_W'(1)),
		out_free:  out_free
	};

endmodule
